@@ rtl/core/plss_pkg.sv @@
// plss_pkg: shared types and constants for the positional list shift store
// no dependencies; imported by the cell, the top level and the checker
package plss_pkg;

   // opcodes of a request
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // fixed port widths
   localparam int OP_W     = 2;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 5;

   // default sizing
   localparam int CAPACITY_DEF   = 16;
   localparam int ITEM_WIDTH_DEF = 32;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic             ins_en;
      logic             rem_en;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

@@ rtl/core/positional_list_shift_store_top.sv @@
// positional_list_shift_store_top: ordered list addressed by position
// depends on plss_pkg and plss_cell
//
// usage
//   request channel (req_valid / req_stall): opcode, position, item_in
//     insert puts item_in at position and shifts later entries up,
//     read returns the entry at position, remove deletes it and shifts
//     later entries down, clear empties the list
//   response channel (rsp_valid / rsp_stall): success, item_out, count
//     one response per request; item_out is all ones on a refused read
//     and zero for every other opcode
//   response timing: registered, so the response appears in the cycle after the request is taken
//   throughput: one request per cycle while no stalled response waits;
//     every cell of the chain shifts together on the same clock edge
//   stall: the response register holds while rsp_stall is high and
//     req_stall is raised so no new request is taken until it drains
//   reset: count goes to zero and the response register empties; the
//     entries keep whatever they held, they are never read unwritten;
//     req_stall stays high while reset is asserted
module positional_list_shift_store_top #(
   parameter int CAPACITY   = plss_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = plss_pkg::ITEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [plss_pkg::OP_W-1:0]    req_opcode,
   input  logic [plss_pkg::POS_W-1:0]   req_position,
   input  logic [plss_pkg::WORD_W-1:0]  req_item_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_success,
   output logic [plss_pkg::WORD_W-1:0]  rsp_item_out,
   output logic [plss_pkg::COUNT_W-1:0] rsp_count
);
   import plss_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

   // list length
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_success_ff, rsp_success_in;
   logic [WORD_W-1:0] rsp_item_ff, rsp_item_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic              accept;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic              not_full;
   logic              pos_in_list;   // position holds an entry
   logic              pos_at_or_in;  // position is an entry or the end
   cell_ctrl_type     ctrl;

   logic [ITEM_WIDTH-1:0] word_store;
   logic [ITEM_WIDTH+WORD_W-1:0] word_wide_in;
   logic [ITEM_WIDTH+WORD_W-1:0] tap_wide;
   logic [CNT_W+COUNT_W-1:0]     count_wide;

   logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
   logic [ITEM_WIDTH-1:0] cell_tap  [CAPACITY];
   logic [ITEM_WIDTH-1:0] read_word;

   // one request in flight: hold off while a response waits on a stall,
   // and take nothing while in reset
   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign pos_ext      = CMP_W'(req_position);
   assign cnt_ext      = CMP_W'(count_ff);
   assign not_full     = (cnt_ext < CMP_W'(CAPACITY));
   assign pos_in_list  = (pos_ext < cnt_ext);
   assign pos_at_or_in = (pos_ext <= cnt_ext);

   // broadcast control to the chain
   always_comb begin
      ctrl.ins_en = accept && (req_opcode == OP_INSERT) && not_full && pos_at_or_in;
      ctrl.rem_en = accept && (req_opcode == OP_REMOVE) && pos_in_list;
      ctrl.pos    = req_position;
   end

   // stored word is the request word cut or zero-extended to the item width
   assign word_wide_in = {{ITEM_WIDTH{1'b0}}, req_item_in};
   assign word_store   = word_wide_in[ITEM_WIDTH-1:0];

   // chain of cells; each takes its left neighbor on insert, right on remove
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_d;
      logic [ITEM_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = word_store;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      plss_cell #(
         .IDX        (i),
         .ITEM_WIDTH (ITEM_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .word_in    (word_store),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .read_tap   (cell_tap[i])
      );
   end

   // read port: only the addressed cell drives a nonzero tap
   always_comb begin
      read_word = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_word = read_word | cell_tap[k];
      end
   end

   assign tap_wide = {{WORD_W{1'b0}}, read_word};

   // next count and response
   always_comb begin
      count_in       = count_ff;
      rsp_success_in = 1'b0;
      rsp_item_in    = '0;
      unique case (req_opcode)
         OP_INSERT: begin
            if (not_full && pos_at_or_in) begin
               count_in       = count_ff + CNT_W'(1);
               rsp_success_in = 1'b1;
            end
         end
         OP_READ: begin
            if (pos_in_list) begin
               rsp_success_in = 1'b1;
               rsp_item_in    = tap_wide[WORD_W-1:0];
            end else begin
               rsp_item_in = '1;
            end
         end
         OP_REMOVE: begin
            if (pos_in_list) begin
               count_in       = count_ff - CNT_W'(1);
               rsp_success_in = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in       = '0;
            rsp_success_in = 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign count_wide   = {{COUNT_W{1'b0}}, count_in};
   assign rsp_count_in = count_wide[COUNT_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only when a request is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_success_ff <= rsp_success_in;
         rsp_item_ff    <= rsp_item_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_success  = rsp_success_ff;
   assign rsp_item_out = rsp_item_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

@@ rtl/core/plss_cell.sv @@
// plss_cell: one list entry of the shift chain
// depends on plss_pkg; instantiated CAPACITY times by the top level
module plss_cell #(
   parameter int IDX        = 0,
   parameter int ITEM_WIDTH = plss_pkg::ITEM_WIDTH_DEF
) (
   input  logic                    clock,
   input  plss_pkg::cell_ctrl_type ctrl,
   input  logic [ITEM_WIDTH-1:0]   word_in,
   input  logic [ITEM_WIDTH-1:0]   left_data,
   input  logic [ITEM_WIDTH-1:0]   right_data,
   output logic [ITEM_WIDTH-1:0]   data,
   output logic [ITEM_WIDTH-1:0]   read_tap
);
   import plss_pkg::*;

   logic [ITEM_WIDTH-1:0] data_ff;
   logic [ITEM_WIDTH-1:0] data_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (32'(ctrl.pos) == 32'(IDX));
   assign above_pos = (32'(ctrl.pos) < 32'(IDX));

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_en) begin
         if (at_pos) data_in = word_in;
         else if (above_pos) data_in = left_data;
      end else if (ctrl.rem_en) begin
         if (at_pos || above_pos) data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign read_tap = at_pos ? data_ff : '0;

endmodule

@@ rtl/core/plss_checker.sv @@
// plss_checker: port-level checks for the positional list shift store
// depends on plss_pkg; bound to positional_list_shift_store_top
module plss_checker #(
   parameter int CAPACITY = plss_pkg::CAPACITY_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [plss_pkg::OP_W-1:0]    req_opcode,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_success,
   input logic [plss_pkg::WORD_W-1:0]  rsp_item_out,
   input logic [plss_pkg::COUNT_W-1:0] rsp_count
);
   import plss_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_success)
         && $stable(rsp_item_out) && $stable(rsp_count))
      else $error("stalled response changed");

   // every taken request yields a response next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("request taken without response");

   // the block only stalls requests behind a waiting response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a pending response");

   // clear always succeeds and empties the list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_CLEAR
         |=> rsp_success && rsp_count == '0 && rsp_item_out == '0)
      else $error("clear response wrong");

   // reported count never exceeds the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_count) <= CAPACITY)
      else $error("response count beyond capacity");

endmodule

bind positional_list_shift_store_top plss_checker #(
   .CAPACITY (CAPACITY)
) u_plss_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_opcode   (req_opcode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_success  (rsp_success),
   .rsp_item_out (rsp_item_out),
   .rsp_count    (rsp_count)
);
